// ----- sv/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg: shared definitions for the Mandelbrot pixel colorizer
// Configuration register indexes, reset values, sequencer states, the
// colour threshold table and the sixteen-entry palette.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int COORD_FRAC_BITS_DEF = 26;
  localparam int PIXEL_BITS_DEF      = 12;
  localparam int COUNT_BITS_DEF      = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORIGIN_W   = 32;
  localparam int STEP_W     = 31;
  localparam int LIMIT_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int PCT_W      = 7;
  localparam int NUM_THR    = 15;
  localparam int PCT_SCALE  = 100;

  localparam logic signed [ORIGIN_W-1:0] ORIGIN_REAL_RST = 32'shF8000000;
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_IMAG_RST = 32'sh06000000;
  localparam logic [STEP_W-1:0]          STEP_REAL_RST   = 31'd262144;
  localparam logic [STEP_W-1:0]          STEP_IMAG_RST   = 31'd262144;
  localparam logic [LIMIT_W-1:0]         LIMIT_RST       = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_ORIGIN_IMAG = 3'd1,
    REG_STEP_REAL   = 3'd2,
    REG_STEP_IMAG   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRE,
    ST_CIM,
    ST_CFIN,
    ST_LOOP,
    ST_WAIT_RR,
    ST_WAIT_II,
    ST_TEST,
    ST_WAIT_RI,
    ST_UPD,
    ST_COLOR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  function automatic logic [PCT_W-1:0] thr_pct(input logic [3:0] idx);
    logic [PCT_W-1:0] k;
    case (idx)
      4'd0:    k = 7'd2;
      4'd1:    k = 7'd4;
      4'd2:    k = 7'd6;
      4'd3:    k = 7'd8;
      4'd4:    k = 7'd10;
      4'd5:    k = 7'd15;
      4'd6:    k = 7'd20;
      4'd7:    k = 7'd40;
      4'd8:    k = 7'd60;
      4'd9:    k = 7'd80;
      4'd10:   k = 7'd90;
      4'd11:   k = 7'd92;
      4'd12:   k = 7'd94;
      4'd13:   k = 7'd96;
      4'd14:   k = 7'd98;
      default: k = 7'd0;
    endcase
    return k;
  endfunction

  function automatic rgb_t palette(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd255, 8'd0,   8'd0};
      4'd2:    c = '{8'd0,   8'd255, 8'd0};
      4'd3:    c = '{8'd0,   8'd0,   8'd255};
      4'd4:    c = '{8'd0,   8'd255, 8'd255};
      4'd5:    c = '{8'd255, 8'd0,   8'd255};
      4'd6:    c = '{8'd0,   8'd0,   8'd255};
      4'd7:    c = '{8'd128, 8'd255, 8'd0};
      4'd8:    c = '{8'd128, 8'd0,   8'd255};
      4'd9:    c = '{8'd0,   8'd255, 8'd128};
      4'd10:   c = '{8'd0,   8'd128, 8'd255};
      4'd11:   c = '{8'd255, 8'd0,   8'd128};
      4'd12:   c = '{8'd255, 8'd128, 8'd0};
      4'd13:   c = '{8'd14,  8'd59,  8'd128};
      4'd14:   c = '{8'd134, 8'd85,  8'd1};
      default: c = '{8'd255, 8'd255, 8'd0};
    endcase
    return c;
  endfunction

endpackage

// ----- sv/mpc_mul.sv -----
// ----------------------------------------------------------------------------
// mpc_mul: shared unsigned multiplier for the iteration loop
// Forms a full COORD_WIDTH by COORD_WIDTH product from 32 by 32 bit partial
// products, one per cycle, each registered and then added into an accumulator.
// ----------------------------------------------------------------------------
module mpc_mul #(
  parameter int COORD_WIDTH = mpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COORD_WIDTH-1:0]   a_i,
  input  logic [COORD_WIDTH-1:0]   b_i,
  output mpc_pkg::mul_stat_t       stat_o,
  output logic [2*COORD_WIDTH-1:0] prod_o
);

  localparam int W    = COORD_WIDTH;
  localparam int DIG  = 32;
  localparam int ND   = (W + DIG - 1) / DIG;
  localparam int PADW = ND * DIG;
  localparam int IW   = (ND > 1) ? $clog2(ND) : 1;
  localparam int SHW  = $clog2(2 * ND);

  logic              run_q, run_d;
  logic              ppv_q, ppv_d;
  logic              done_q, done_d;
  logic [IW-1:0]     i_q, i_d, j_q, j_d;
  logic              pplast_q, pplast_d;
  logic [SHW-1:0]    ppsh_q, ppsh_d;
  logic [2*DIG-1:0]  pp_q, pp_d;
  logic [2*PADW-1:0] acc_q, acc_d;
  logic [PADW-1:0]   a_pad, b_pad;
  logic [DIG-1:0]    a_dig, b_dig;
  logic              last;

  always_comb begin
    a_pad    = PADW'(a_i);
    b_pad    = PADW'(b_i);
    a_dig    = DIG'(a_pad >> (DIG * i_q));
    b_dig    = DIG'(b_pad >> (DIG * j_q));
    last     = (i_q == IW'(ND - 1)) && (j_q == IW'(ND - 1));
    run_d    = run_q;
    i_d      = i_q;
    j_d      = j_q;
    ppv_d    = 1'b0;
    pplast_d = pplast_q;
    ppsh_d   = ppsh_q;
    pp_d     = pp_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    if (ppv_q) begin
      acc_d  = acc_q + ((2 * PADW)'(pp_q) << (DIG * ppsh_q));
      done_d = pplast_q;
    end
    if (start_i) begin
      run_d = 1'b1;
      i_d   = '0;
      j_d   = '0;
      acc_d = '0;
    end else if (run_q) begin
      pp_d     = (2 * DIG)'(a_dig) * (2 * DIG)'(b_dig);
      ppv_d    = 1'b1;
      pplast_d = last;
      ppsh_d   = SHW'(i_q) + SHW'(j_q);
      if (last) begin
        run_d = 1'b0;
      end else if (j_q == IW'(ND - 1)) begin
        j_d = '0;
        i_d = i_q + IW'(1);
      end else begin
        j_d = j_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      run_q  <= run_d;
      ppv_q  <= ppv_d;
      done_q <= done_d;
      i_q    <= i_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pplast_q <= pplast_d;
    ppsh_q   <= ppsh_d;
    pp_q     <= pp_d;
    acc_q    <= acc_d;
  end

  assign stat_o.busy = run_q | ppv_q;
  assign stat_o.done = done_q;
  assign prod_o      = (2 * W)'(acc_q);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !(run_q || ppv_q))
    else $error("multiplier started while busy");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (run_q && !ppv_q))
    else $error("multiplier did not begin issuing after start");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!run_q && !ppv_q))
    else $error("product reported done with partial products pending");

endmodule

// ----- sv/mandelbrot_pixel_colorizer_core.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colorizer_core: escape-time colouring of one pixel
// Maps a pixel to a point c, iterates z = z*z + c on one shared multiplier
// until |z| > 4 or the iteration limit, and turns the count into a colour.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                                  Beat
// s_axis    in         pixel_col, pixel_row                     tvalid & tready
// m_axis    out        red, green, blue, escape_count           tvalid & tready
// cfg       in         cfg_index_i, cfg_data_i                  cfg_valid_i & cfg_ready_o
//
// Each pixel passes the setup states ST_CRE, ST_CIM and ST_CFIN after its
// input beat. Each iteration then runs ST_LOOP, the squares of the real and
// imaginary parts on the shared multiplier, which sums one partial product per
// pair of 32-bit digits, the escape test, the cross product and the update. An
// escape ends the pixel at the test; the limit is caught by the ST_LOOP check.
// Colour lookup then walks the threshold table and loads the output register.
// The input is ready only while the sequencer is idle; a result waiting on
// m_axis does not block the next pixel until its own result is ready.
// Reset restores the configuration registers and empties the output register.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_colorizer_core #(
  parameter int COORD_WIDTH     = mpc_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = mpc_pkg::COORD_FRAC_BITS_DEF,
  parameter int PIXEL_BITS      = mpc_pkg::PIXEL_BITS_DEF,
  parameter int COUNT_BITS      = mpc_pkg::COUNT_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // pixel_col, pixel_row
  input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]               s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // red, green, blue, escape_count
  output logic [((3*mpc_pkg::COLOR_W+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]                   cfg_index_i,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]                  cfg_data_i
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = COORD_FRAC_BITS;
  localparam int P     = PIXEL_BITS;
  localparam int N     = COUNT_BITS;
  localparam int OUT_W = ((3 * mpc_pkg::COLOR_W + N + 7) / 8) * 8;
  localparam int PW    = P + mpc_pkg::STEP_W;
  localparam int SUMW  = ((PW > mpc_pkg::ORIGIN_W) ? PW : mpc_pkg::ORIGIN_W) + 2;
  localparam int DW    = F + 6;
  localparam int M1    = (SUMW > W) ? SUMW : W;
  localparam int SATW  = ((M1 > DW) ? M1 : DW) + 1;
  localparam int EW    = ((2 * W + 1) > (2 * F + 6)) ? (2 * W + 1) : (2 * F + 6);
  localparam int LCW   = (mpc_pkg::LIMIT_W > N) ? mpc_pkg::LIMIT_W : N;
  localparam int SCW   = N + mpc_pkg::PCT_W;

  localparam logic signed [SATW-1:0] ZMAX = {{(SATW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SATW-1:0] ZMIN = ~ZMAX;
  localparam logic [EW-1:0]          BOUND = EW'(1) << (2 * F + 4);
  localparam logic [LCW-1:0]         CMAX = LCW'((1 << N) - 1);

  function automatic logic signed [W-1:0] sat_c(input logic signed [SATW-1:0] v);
    if (v > ZMAX) begin
      return W'(ZMAX);
    end else if (v < ZMIN) begin
      return W'(ZMIN);
    end
    return W'(v);
  endfunction

  mpc_pkg::state_e state_q, state_d;

  logic signed [mpc_pkg::ORIGIN_W-1:0] origin_real_q, origin_imag_q;
  logic [mpc_pkg::STEP_W-1:0]          step_real_q, step_imag_q;
  logic [mpc_pkg::LIMIT_W-1:0]         limit_q;

  logic [P-1:0]          col_q, col_d, row_q, row_d;
  logic [PW-1:0]         cprod_q, cprod_d;
  logic signed [W-1:0]   cre_q, cre_d, cim_q, cim_d, zre_q, zre_d, zim_q, zim_d;
  logic [N-1:0]          iter_q, iter_d, count_q, count_d;
  logic [2*W-1:0]        r2_q, r2_d;
  logic signed [DW-1:0]  dre_q, dre_d;
  logic [SCW-1:0]        scaled_q, scaled_d;
  logic [3:0]            cidx_q, cidx_d;
  logic                  m_valid_q, m_valid_d;
  mpc_pkg::rgb_t         out_rgb_q, out_rgb_d;
  logic [N-1:0]          out_count_q, out_count_d;

  logic                  in_beat, out_load;
  logic                  mul_start;
  logic [W-1:0]          mul_a, mul_b, ar, ai;
  mpc_pkg::mul_stat_t    mul_stat;
  logic [2*W-1:0]        prod;
  logic [P-1:0]          cm_a;
  logic [mpc_pkg::STEP_W-1:0] cm_b;
  logic [PW-1:0]         cm_prod;
  logic signed [SUMW-1:0] cre_sum, cim_sum;
  logic [LCW-1:0]        lim_wide;
  logic [N-1:0]          lim;
  logic [EW-1:0]         esc_sum;
  logic                  escape;
  logic signed [2*W:0]   sq_diff;
  logic [2*W-1:0]        p_floor;
  logic                  p_lost, p_neg;
  logic [DW-1:0]         p_mag;
  logic signed [DW-1:0]  dim;
  logic [SCW-1:0]        thr;
  logic                  color_hit;

  mpc_mul #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  always_comb begin
    ar        = zre_q[W-1] ? unsigned'(-zre_q) : unsigned'(zre_q);
    ai        = zim_q[W-1] ? unsigned'(-zim_q) : unsigned'(zim_q);
    lim_wide  = LCW'(limit_q);
    lim       = N'((lim_wide > CMAX) ? CMAX : lim_wide);
    cm_a      = (state_q == mpc_pkg::ST_CRE) ? col_q : row_q;
    cm_b      = (state_q == mpc_pkg::ST_CRE) ? step_real_q : step_imag_q;
    cm_prod   = PW'(cm_a) * PW'(cm_b);
    cre_sum   = SUMW'(origin_real_q) + $signed(SUMW'(cprod_q));
    cim_sum   = SUMW'(origin_imag_q) - $signed(SUMW'(cprod_q));
    esc_sum   = EW'(r2_q) + EW'(prod);
    escape    = esc_sum > BOUND;
    sq_diff   = $signed({1'b0, r2_q}) - $signed({1'b0, prod});
    p_floor   = prod >> (F - 1);
    p_lost    = |prod[F-2:0];
    p_neg     = (zre_q[W-1] ^ zim_q[W-1]) && (|prod);
    p_mag     = DW'(p_floor) + DW'(p_neg && p_lost);
    dim       = p_neg ? -$signed(p_mag) : $signed(p_mag);
    thr       = SCW'(mpc_pkg::thr_pct(cidx_q)) * SCW'(lim);
    color_hit = (cidx_q == 4'(mpc_pkg::NUM_THR)) || (scaled_q < thr);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpc_pkg::ST_IDLE:    if (in_beat) state_d = mpc_pkg::ST_CRE;
      mpc_pkg::ST_CRE:     state_d = mpc_pkg::ST_CIM;
      mpc_pkg::ST_CIM:     state_d = mpc_pkg::ST_CFIN;
      mpc_pkg::ST_CFIN:    state_d = mpc_pkg::ST_LOOP;
      mpc_pkg::ST_LOOP:    state_d = (iter_q == lim) ? mpc_pkg::ST_COLOR : mpc_pkg::ST_WAIT_RR;
      mpc_pkg::ST_WAIT_RR: if (mul_stat.done) state_d = mpc_pkg::ST_WAIT_II;
      mpc_pkg::ST_WAIT_II: if (mul_stat.done) state_d = mpc_pkg::ST_TEST;
      mpc_pkg::ST_TEST:    state_d = escape ? mpc_pkg::ST_COLOR : mpc_pkg::ST_WAIT_RI;
      mpc_pkg::ST_WAIT_RI: if (mul_stat.done) state_d = mpc_pkg::ST_UPD;
      mpc_pkg::ST_UPD:     state_d = mpc_pkg::ST_LOOP;
      mpc_pkg::ST_COLOR:   if (color_hit) state_d = mpc_pkg::ST_DONE;
      mpc_pkg::ST_DONE:    if (out_load) state_d = mpc_pkg::ST_IDLE;
      default:             state_d = mpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    out_load      = 1'b0;
    mul_a         = ar;
    mul_b         = ai;
    unique case (state_q)
      mpc_pkg::ST_IDLE:    s_axis_tready = 1'b1;
      mpc_pkg::ST_LOOP:    mul_start = (iter_q != lim);
      mpc_pkg::ST_WAIT_RR: begin
        mul_a     = ar;
        mul_b     = ar;
        mul_start = mul_stat.done;
      end
      mpc_pkg::ST_WAIT_II: begin
        mul_a = ai;
        mul_b = ai;
      end
      mpc_pkg::ST_TEST:    mul_start = !escape;
      mpc_pkg::ST_DONE:    out_load = !m_valid_q || m_axis_tready;
      default: begin
      end
    endcase
  end

  assign in_beat = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    cprod_d     = cprod_q;
    cre_d       = cre_q;
    cim_d       = cim_q;
    zre_d       = zre_q;
    zim_d       = zim_q;
    iter_d      = iter_q;
    count_d     = count_q;
    r2_d        = r2_q;
    dre_d       = dre_q;
    cidx_d      = cidx_q;
    out_rgb_d   = out_rgb_q;
    out_count_d = out_count_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    unique case (state_q)
      mpc_pkg::ST_IDLE: begin
        if (in_beat) begin
          col_d = s_axis_tdata[P-1:0];
          row_d = s_axis_tdata[2*P-1:P];
        end
      end
      mpc_pkg::ST_CRE:  cprod_d = cm_prod;
      mpc_pkg::ST_CIM: begin
        cre_d   = sat_c(SATW'(cre_sum));
        cprod_d = cm_prod;
      end
      mpc_pkg::ST_CFIN: begin
        cim_d  = sat_c(SATW'(cim_sum));
        zim_d  = sat_c(SATW'(cim_sum));
        zre_d  = cre_q;
        iter_d = '0;
      end
      mpc_pkg::ST_LOOP: begin
        count_d = lim;
        cidx_d  = '0;
      end
      mpc_pkg::ST_WAIT_RR: if (mul_stat.done) r2_d = prod;
      mpc_pkg::ST_TEST: begin
        count_d = iter_q;
        cidx_d  = '0;
        dre_d   = DW'(sq_diff >>> F);
      end
      mpc_pkg::ST_UPD: begin
        zre_d  = sat_c(SATW'(dre_q) + SATW'(cre_q));
        zim_d  = sat_c(SATW'(dim) + SATW'(cim_q));
        iter_d = iter_q + N'(1);
      end
      mpc_pkg::ST_COLOR: if (!color_hit) cidx_d = cidx_q + 4'd1;
      mpc_pkg::ST_DONE: begin
        if (out_load) begin
          out_rgb_d   = mpc_pkg::palette(cidx_q);
          out_count_d = count_q;
          m_valid_d   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    scaled_d = SCW'(count_d) * SCW'(mpc_pkg::PCT_SCALE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mpc_pkg::ST_IDLE;
      m_valid_q     <= 1'b0;
      iter_q        <= '0;
      cidx_q        <= '0;
      origin_real_q <= mpc_pkg::ORIGIN_REAL_RST;
      origin_imag_q <= mpc_pkg::ORIGIN_IMAG_RST;
      step_real_q   <= mpc_pkg::STEP_REAL_RST;
      step_imag_q   <= mpc_pkg::STEP_IMAG_RST;
      limit_q       <= mpc_pkg::LIMIT_RST;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      iter_q    <= iter_d;
      cidx_q    <= cidx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mpc_pkg::REG_ORIGIN_REAL: origin_real_q <= signed'(cfg_data_i);
          mpc_pkg::REG_ORIGIN_IMAG: origin_imag_q <= signed'(cfg_data_i);
          mpc_pkg::REG_STEP_REAL:   step_real_q   <= cfg_data_i[mpc_pkg::STEP_W-1:0];
          mpc_pkg::REG_STEP_IMAG:   step_imag_q   <= cfg_data_i[mpc_pkg::STEP_W-1:0];
          mpc_pkg::REG_ITER_LIMIT:  limit_q       <= cfg_data_i[mpc_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q       <= col_d;
    row_q       <= row_d;
    cprod_q     <= cprod_d;
    cre_q       <= cre_d;
    cim_q       <= cim_d;
    zre_q       <= zre_d;
    zim_q       <= zim_d;
    count_q     <= count_d;
    r2_q        <= r2_d;
    dre_q       <= dre_d;
    scaled_q    <= scaled_d;
    out_rgb_q   <= out_rgb_d;
    out_count_q <= out_count_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({out_count_q, out_rgb_q.blue, out_rgb_q.green,
                                 out_rgb_q.red});

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpc_pkg::ST_DONE && (!m_valid_q || m_axis_tready))
    |=> (m_valid_q && state_q == mpc_pkg::ST_IDLE))
    else $error("finished pixel did not reach the output register");

  a_start_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> (state_q == mpc_pkg::ST_WAIT_RR || state_q == mpc_pkg::ST_WAIT_II ||
                   state_q == mpc_pkg::ST_WAIT_RI))
    else $error("multiplier started outside a product wait");

  a_idle_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mul_stat.busy)
    else $error("input ready while the multiplier is still working");

endmodule
